@@ rtl/mvn_pkg.sv @@
// Shared types and constants for the mesh vertex normal unit.
// Used by mvn_norm and mesh_vertex_normals_unit; depends on nothing.
package mvn_pkg;

  localparam int MVN_MAX_CORNERS = 16;
  localparam int MVN_MAX_FACES   = 32;

  localparam int POS_W    = 16;
  localparam int IDX_W    = 8;
  localparam int NRM_W    = 16;
  localparam int NRM_FRAC = 14;
  localparam int ITEM_W   = 5;
  // Normalizer input: wide enough for a cross product of 17-bit differences.
  localparam int VEC_W    = 36;

  localparam logic [1:0] REQ_CORNER = 2'd0;
  localparam logic [1:0] REQ_FACE   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_CORNER = 1'b1;

  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    nrm_t x;
    nrm_t y;
    nrm_t z;
  } nvec_t;

endpackage

@@ rtl/mvn_norm.sv @@
// Iterative vector normalizer: range reduction, sum of squares on one
// multiplier, bitwise square root and restoring division. Uses mvn_pkg.
module mvn_norm import mvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  input  logic signed [VEC_W-1:0] vec_z,
  output logic                    done,
  output nvec_t                   res
);

  localparam int MAG_W = VEC_W - 1;
  localparam int RED_W = 30;
  localparam int SQ_W  = 2 * RED_W;
  localparam int S_W   = SQ_W + 2;
  localparam int R_W   = S_W + 1;
  localparam int L_W   = RED_W + 2;
  localparam int D_W   = L_W + NRM_FRAC;
  localparam int Q_W   = NRM_FRAC + 1;

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV, N_OUT} nst_t;

  nst_t             st_r;
  logic [MAG_W-1:0] m_r [3];
  logic             neg_r [3];
  logic [4:0]       cnt_r;
  logic [1:0]       k_r;
  logic [SQ_W-1:0]  prod_r;
  logic [S_W-1:0]   s_r;
  logic [S_W-1:0]   n_r;
  logic [R_W-1:0]   r_r;
  logic [R_W-1:0]   bit_r;
  logic [L_W-1:0]   len_r;
  logic [D_W-1:0]   num_r;
  logic [D_W-1:0]   dsh_r;
  logic [Q_W-1:0]   q_r;
  nrm_t             res_r [3];

  logic             big;
  logic [RED_W-1:0] sq_in;
  logic [RED_W-1:0] dv_in;
  logic [S_W-1:0]   s_sum;
  logic [R_W-1:0]   trial;
  logic             take;
  logic [R_W-1:0]   r_new;
  logic             qb;
  logic [Q_W-1:0]   q_new;

  always_comb begin
    big = (|m_r[0][MAG_W-1:RED_W]) | (|m_r[1][MAG_W-1:RED_W]) | (|m_r[2][MAG_W-1:RED_W]);
    case (cnt_r[1:0])
      2'd0:    sq_in = m_r[0][RED_W-1:0];
      2'd1:    sq_in = m_r[1][RED_W-1:0];
      default: sq_in = m_r[2][RED_W-1:0];
    endcase
    case (k_r)
      2'd0:    dv_in = m_r[0][RED_W-1:0];
      2'd1:    dv_in = m_r[1][RED_W-1:0];
      default: dv_in = m_r[2][RED_W-1:0];
    endcase
    s_sum = s_r + S_W'(prod_r);
    trial = r_r + bit_r;
    take  = ({1'b0, n_r} >= trial);
    r_new = take ? ((r_r >> 1) + bit_r) : (r_r >> 1);
    qb    = (num_r >= dsh_r);
    q_new = {q_r[Q_W-2:0], qb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      case (st_r)
        N_IDLE: begin
          if (start) begin
            neg_r[0] <= vec_x[VEC_W-1];
            neg_r[1] <= vec_y[VEC_W-1];
            neg_r[2] <= vec_z[VEC_W-1];
            m_r[0]   <= vec_x[VEC_W-1] ? MAG_W'(-vec_x) : MAG_W'(vec_x);
            m_r[1]   <= vec_y[VEC_W-1] ? MAG_W'(-vec_y) : MAG_W'(vec_y);
            m_r[2]   <= vec_z[VEC_W-1] ? MAG_W'(-vec_z) : MAG_W'(vec_z);
            st_r     <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // All components drop one bit together until every one fits 30 bits.
          if (big) begin
            m_r[0] <= m_r[0] >> 1;
            m_r[1] <= m_r[1] >> 1;
            m_r[2] <= m_r[2] >> 1;
          end else begin
            cnt_r <= '0;
            s_r   <= '0;
            st_r  <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt_r != 5'd0) s_r <= s_sum;
          if (cnt_r != 5'd3) prod_r <= sq_in * sq_in;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            if (s_sum == '0) begin
              res_r[0] <= '0;
              res_r[1] <= '0;
              res_r[2] <= '0;
              st_r     <= N_OUT;
            end else begin
              n_r   <= s_sum;
              r_r   <= '0;
              bit_r <= R_W'(1) << (R_W - 1);
              cnt_r <= '0;
              st_r  <= N_SQRT;
            end
          end
        end
        N_SQRT: begin
          if (take) n_r <= n_r - S_W'(trial);
          r_r   <= r_new;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            len_r <= L_W'(r_new);
            k_r   <= '0;
            st_r  <= N_DSET;
          end
        end
        N_DSET: begin
          num_r <= D_W'({dv_in, {NRM_FRAC{1'b0}}}) + D_W'(len_r >> 1);
          dsh_r <= D_W'({len_r, {NRM_FRAC{1'b0}}});
          q_r   <= '0;
          cnt_r <= '0;
          st_r  <= N_DIV;
        end
        N_DIV: begin
          if (qb) num_r <= num_r - dsh_r;
          dsh_r <= dsh_r >> 1;
          q_r   <= q_new;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(NRM_FRAC)) begin
            res_r[k_r] <= neg_r[k_r] ? -NRM_W'(q_new) : NRM_W'(q_new);
            if (k_r == 2'd2) begin
              st_r <= N_OUT;
            end else begin
              k_r  <= k_r + 2'd1;
              st_r <= N_DSET;
            end
          end
        end
        N_OUT: begin
          st_r <= N_IDLE;
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign done  = (st_r == N_OUT);
  assign res.x = res_r[0];
  assign res.y = res_r[1];
  assign res.z = res_r[2];

endmodule

@@ rtl/mesh_vertex_normals_unit.sv @@
// Mesh vertex normal unit: loads corners and triangles, then on finish emits face normals,
// then corner normals. Uses mvn_pkg and mvn_norm. Load words are accepted while idle.
// A finish normalizes each face (a face with a bad index gets a zero normal and no
// normalization), then for each corner sums the normals of the stored faces that use it
// and normalizes the sum; output stalls hold the walk. No input is taken
// while a finish runs. Reset clears the counts; the position and face stores hold old data.
module mesh_vertex_normals_unit import mvn_pkg::*; #(
  parameter int MAX_CORNERS = MVN_MAX_CORNERS,
  parameter int MAX_FACES   = MVN_MAX_FACES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [IDX_W-1:0]        in_vert_a,
  input  logic [IDX_W-1:0]        in_vert_b,
  input  logic [IDX_W-1:0]        in_vert_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [ITEM_W-1:0]       out_item_index,
  output logic signed [NRM_W-1:0] out_norm_x,
  output logic signed [NRM_W-1:0] out_norm_y,
  output logic signed [NRM_W-1:0] out_norm_z,
  output logic                    out_last
);

  localparam int CIW  = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
  localparam int FIW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CCW  = $clog2(MAX_CORNERS + 1);
  localparam int FCW  = $clog2(MAX_FACES + 1);
  localparam int SUMW = FIW + NRM_W;
  localparam int DW   = POS_W + 1;
  localparam int PW   = 2 * DW;
  localparam int CRW  = PW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_F_RD, ST_F_IDX, ST_F_RA, ST_F_RB, ST_F_RC, ST_F_MUL, ST_F_NORM,
    ST_F_WAIT, ST_F_EMIT, ST_C_START, ST_C_RD, ST_C_ACC, ST_C_NORM, ST_C_WAIT, ST_C_EMIT
  } st_t;

  pos_t                  corner_mem [MAX_CORNERS];
  logic [3*IDX_W-1:0]    face_mem [MAX_FACES];
  nvec_t                 fn_mem [MAX_FACES];

  st_t                   state_r;
  logic [CCW-1:0]        corner_count_r;
  logic [FCW-1:0]        face_count_r;
  logic [FCW-1:0]        fi_r;
  logic [FCW-1:0]        fj_r;
  logic [CCW-1:0]        ci_r;
  logic [2:0]            mcnt_r;
  pos_t                  corn_q_r;
  logic [3*IDX_W-1:0]    face_q_r;
  nvec_t                 fn_q_r;
  pos_t                  pa_r;
  pos_t                  pb_r;
  logic signed [DW-1:0]  d1_r [3];
  logic signed [DW-1:0]  d2_r [3];
  logic signed [PW-1:0]  prod_r;
  logic signed [CRW-1:0] cr_r [3];
  logic signed [SUMW-1:0] sum_r [3];
  nvec_t                 nrm_r;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [ITEM_W-1:0]     out_item_r;
  nvec_t                 out_nrm_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic                  corn_we;
  logic                  face_we;
  logic                  corn_re;
  logic                  face_re;
  logic [CIW-1:0]        corn_ra;
  logic [FIW-1:0]        face_ra;
  logic [IDX_W-1:0]      fa;
  logic [IDX_W-1:0]      fb;
  logic [IDX_W-1:0]      fc;
  logic                  bad;
  logic                  hit;
  logic signed [DW-1:0]  mul_a;
  logic signed [DW-1:0]  mul_b;
  logic                  norm_start;
  logic                  norm_done;
  nvec_t                 norm_res;
  logic signed [VEC_W-1:0] nv_x;
  logic signed [VEC_W-1:0] nv_y;
  logic signed [VEC_W-1:0] nv_z;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == ST_F_EMIT) || (state_r == ST_C_EMIT));

  assign fa  = face_q_r[3*IDX_W-1:2*IDX_W];
  assign fb  = face_q_r[2*IDX_W-1:IDX_W];
  assign fc  = face_q_r[IDX_W-1:0];
  assign bad = (fa >= IDX_W'(corner_count_r)) || (fb >= IDX_W'(corner_count_r)) ||
               (fc >= IDX_W'(corner_count_r));
  assign hit = (fa == IDX_W'(ci_r)) || (fb == IDX_W'(ci_r)) || (fc == IDX_W'(ci_r));

  assign corn_we = in_acc && (in_req_type == REQ_CORNER) &&
                   (corner_count_r != CCW'(MAX_CORNERS));
  assign face_we = in_acc && (in_req_type == REQ_FACE) &&
                   (face_count_r != FCW'(MAX_FACES));
  assign corn_re = (state_r == ST_F_IDX) || (state_r == ST_F_RA) || (state_r == ST_F_RB);
  assign face_re = (state_r == ST_F_RD) || (state_r == ST_C_RD);
  assign face_ra = (state_r == ST_F_RD) ? fi_r[FIW-1:0] : fj_r[FIW-1:0];

  always_comb begin
    case (state_r)
      ST_F_RA: corn_ra = fb[CIW-1:0];
      ST_F_RB: corn_ra = fc[CIW-1:0];
      default: corn_ra = fa[CIW-1:0];
    endcase
    // Cross product terms, one product a cycle.
    case (mcnt_r)
      3'd0:    begin mul_a = d1_r[1]; mul_b = d2_r[2]; end
      3'd1:    begin mul_a = d1_r[2]; mul_b = d2_r[1]; end
      3'd2:    begin mul_a = d1_r[2]; mul_b = d2_r[0]; end
      3'd3:    begin mul_a = d1_r[0]; mul_b = d2_r[2]; end
      3'd4:    begin mul_a = d1_r[0]; mul_b = d2_r[1]; end
      default: begin mul_a = d1_r[1]; mul_b = d2_r[0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (corn_we) corner_mem[corner_count_r[CIW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    if (corn_re) corn_q_r <= corner_mem[corn_ra];
  end

  always_ff @(posedge clk) begin
    if (face_we) face_mem[face_count_r[FIW-1:0]] <= {in_vert_a, in_vert_b, in_vert_c};
    if (face_re) face_q_r <= face_mem[face_ra];
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_F_EMIT) && out_free) fn_mem[fi_r[FIW-1:0]] <= nrm_r;
    if (face_re) fn_q_r <= fn_mem[face_ra];
  end

  assign norm_start = (state_r == ST_F_NORM) || (state_r == ST_C_NORM);
  assign nv_x = (state_r == ST_C_NORM) ? VEC_W'(sum_r[0]) : VEC_W'(cr_r[0]);
  assign nv_y = (state_r == ST_C_NORM) ? VEC_W'(sum_r[1]) : VEC_W'(cr_r[1]);
  assign nv_z = (state_r == ST_C_NORM) ? VEC_W'(sum_r[2]) : VEC_W'(cr_r[2]);

  mvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec_x (nv_x),
    .vec_y (nv_y),
    .vec_z (nv_z),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      corner_count_r <= '0;
      face_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (corn_we) corner_count_r <= corner_count_r + CCW'(1);
          if (face_we) face_count_r <= face_count_r + FCW'(1);
          if (in_acc && (in_req_type == REQ_FINISH)) begin
            fi_r    <= '0;
            state_r <= ST_F_RD;
          end
        end
        ST_F_RD: begin
          if (fi_r == face_count_r) begin
            ci_r    <= '0;
            state_r <= ST_C_START;
          end else begin
            state_r <= ST_F_IDX;
          end
        end
        ST_F_IDX: begin
          if (bad) begin
            nrm_r   <= '0;
            state_r <= ST_F_EMIT;
          end else begin
            state_r <= ST_F_RA;
          end
        end
        ST_F_RA: begin
          pa_r    <= corn_q_r;
          state_r <= ST_F_RB;
        end
        ST_F_RB: begin
          pb_r    <= corn_q_r;
          state_r <= ST_F_RC;
        end
        ST_F_RC: begin
          d1_r[0] <= DW'(pb_r.x) - DW'(pa_r.x);
          d1_r[1] <= DW'(pb_r.y) - DW'(pa_r.y);
          d1_r[2] <= DW'(pb_r.z) - DW'(pa_r.z);
          d2_r[0] <= DW'(corn_q_r.x) - DW'(pa_r.x);
          d2_r[1] <= DW'(corn_q_r.y) - DW'(pa_r.y);
          d2_r[2] <= DW'(corn_q_r.z) - DW'(pa_r.z);
          mcnt_r  <= '0;
          state_r <= ST_F_MUL;
        end
        ST_F_MUL: begin
          if (mcnt_r != 3'd6) prod_r <= mul_a * mul_b;
          case (mcnt_r)
            3'd1:    cr_r[0] <= CRW'(prod_r);
            3'd2:    cr_r[0] <= cr_r[0] - CRW'(prod_r);
            3'd3:    cr_r[1] <= CRW'(prod_r);
            3'd4:    cr_r[1] <= cr_r[1] - CRW'(prod_r);
            3'd5:    cr_r[2] <= CRW'(prod_r);
            3'd6:    cr_r[2] <= cr_r[2] - CRW'(prod_r);
            default: ;
          endcase
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd6) state_r <= ST_F_NORM;
        end
        ST_F_NORM: state_r <= ST_F_WAIT;
        ST_F_WAIT: begin
          if (norm_done) begin
            nrm_r   <= norm_res;
            state_r <= ST_F_EMIT;
          end
        end
        ST_F_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_FACE;
            out_item_r  <= ITEM_W'(fi_r);
            out_nrm_r   <= nrm_r;
            out_last_r  <= (FCW'(fi_r + FCW'(1)) == face_count_r) && (corner_count_r == '0);
            fi_r        <= fi_r + FCW'(1);
            state_r     <= ST_F_RD;
          end
        end
        ST_C_START: begin
          if (ci_r == corner_count_r) begin
            corner_count_r <= '0;
            face_count_r   <= '0;
            state_r        <= ST_IDLE;
          end else begin
            sum_r[0] <= '0;
            sum_r[1] <= '0;
            sum_r[2] <= '0;
            fj_r     <= '0;
            state_r  <= ST_C_RD;
          end
        end
        ST_C_RD: begin
          state_r <= (fj_r == face_count_r) ? ST_C_NORM : ST_C_ACC;
        end
        ST_C_ACC: begin
          if (hit) begin
            sum_r[0] <= sum_r[0] + SUMW'(fn_q_r.x);
            sum_r[1] <= sum_r[1] + SUMW'(fn_q_r.y);
            sum_r[2] <= sum_r[2] + SUMW'(fn_q_r.z);
          end
          fj_r    <= fj_r + FCW'(1);
          state_r <= ST_C_RD;
        end
        ST_C_NORM: state_r <= ST_C_WAIT;
        ST_C_WAIT: begin
          if (norm_done) begin
            nrm_r   <= norm_res;
            state_r <= ST_C_EMIT;
          end
        end
        ST_C_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_CORNER;
            out_item_r  <= ITEM_W'(ci_r);
            out_nrm_r   <= nrm_r;
            out_last_r  <= (CCW'(ci_r + CCW'(1)) == corner_count_r);
            ci_r        <= ci_r + CCW'(1);
            state_r     <= ST_C_START;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_item_index = out_item_r;
  assign out_norm_x     = out_nrm_r.x;
  assign out_norm_y     = out_nrm_r.y;
  assign out_norm_z     = out_nrm_r.z;
  assign out_last       = out_last_r;

  // The counts only change in idle or when a finish run wraps up.
  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && !((state_r == ST_C_START) && (ci_r == corner_count_r))
    |=> $stable(face_count_r) && $stable(corner_count_r))
    else $error("counts changed during a finish run");

  a_norm_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == ST_F_WAIT) || (state_r == ST_C_WAIT))
    else $error("normalizer finished while nobody waited");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall
    |=> out_valid_r && $stable(out_kind_r) && $stable(out_item_r) && $stable(out_nrm_r) &&
        $stable(out_last_r))
    else $error("stalled output word changed");

  a_face_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_RD) |-> (fi_r <= face_count_r))
    else $error("face walk ran past the face count");

endmodule
